// ===== design/rtg_pkg.sv =====
package rtg_pkg;
  localparam int MaxTokenLen = 16;
  localparam int MinTokenLen = 6;
  localparam int LenSpan = (MaxTokenLen >= MinTokenLen) ? (MaxTokenLen - MinTokenLen + 1) : 1;
  localparam int BufDepth = (MaxTokenLen > MinTokenLen) ? MaxTokenLen : MinTokenLen;
  localparam int BufIdxW = $clog2(BufDepth);
  localparam int LenW = $clog2(BufDepth + 1);
  localparam int KuW = 37;
  localparam int KeyChunks = (KuW + 7) / 8;
  localparam int KeyPadW = 8 * KeyChunks;
  localparam logic [KuW-1:0] KuReset = 37'd8000000;
  localparam logic [63:0] SeedReset = 64'h0123456789abcdef;
  localparam logic [6:0] NlCode = 7'd10;
  localparam logic [6:0] Radix = 7'd66;
  localparam logic [63:0] Golden = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] Mul1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] Mul2 = 64'h94d049bb133111eb;
  localparam logic [1:0] RegKu = 2'd0;
  localparam logic [1:0] RegSeed = 2'd1;
  localparam int LenRecipShift = 26;
  localparam logic [26:0] LenRecip = 27'(((1 << LenRecipShift) + LenSpan - 1) / LenSpan);
  localparam logic [12:0] LenSpanW = 13'(LenSpan);
  localparam int DigRecipShift = 24;
  localparam logic [17:0] DigRecip =
    18'(((1 << DigRecipShift) + int'(Radix) - 1) / int'(Radix));

  typedef struct packed {
    logic [KuW-1:0] key;
    logic [LenW-1:0] len;
  } rtg_job_t;

  function automatic logic [6:0] glyph(input logic [6:0] d);
    logic [6:0] g;
    begin
      if (d < 7'd10) g = 7'd48 + d;
      else if (d < 7'd36) g = 7'd87 + d;
      else if (d < 7'd62) g = 7'd29 + d;
      else begin
        case (d)
          7'd62: g = 7'd64;
          7'd63: g = 7'd35;
          7'd64: g = 7'd37;
          default: g = 7'd42;
        endcase
      end
      return g;
    end
  endfunction
endpackage

// ===== design/rtg_front.sv =====
module rtg_front import rtg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_bit,
  output logic req_stall,
  input  logic [KuW-1:0] key_universe,
  input  logic seed_load,
  input  logic [63:0] seed_value,
  output logic job_valid,
  output rtg_job_t job,
  input  logic job_take
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MOD = 5'b00010, S_MIX = 5'b00100,
    S_LEN = 5'b01000, S_DONE = 5'b10000
  } state_t;
  state_t state;
  logic [63:0] gen_state;
  logic [63:0] v;
  logic [KuW-1:0] rem;
  logic [KuW-1:0] modulus;
  logic [5:0] bit_cnt;
  logic [63:0] x1, x2, x3;
  logic [KuW:0] rem_sh;
  logic [KuW+1:0] trial;
  logic [KuW-1:0] rem_next;
  logic [63:0] r1, r2, r3;
  logic mix_round;
  logic [1:0] mix_step;
  logic [63:0] mul_a, mul_b, acc;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;
  logic [3:0] len_cnt;
  logic [63:0] hsh;
  logic [4:0] len_rem;
  logic [12:0] len_x, len_q, len_r;
  logic [39:0] len_prod;

  assign req_stall = !(state == S_IDLE);
  assign job_valid = (state == S_DONE);
  assign x1 = gen_state ^ (gen_state << 13);
  assign x2 = x1 ^ (x1 >> 7);
  assign x3 = x2 ^ (x2 << 17);
  assign rem_sh = {rem, v[63]};
  assign trial = {1'b0, rem_sh} - {2'b00, modulus};
  assign rem_next = trial[KuW+1] ? rem_sh[KuW-1:0] : trial[KuW-1:0];
  assign r1 = v ^ (v >> 30);
  assign r2 = v ^ (v >> 27);
  assign r3 = v ^ (v >> 31);
  assign mul_a = mix_round ? r2 : r1;
  assign mul_b = mix_round ? Mul2 : Mul1;
  assign mul_x = (mix_step == 2'd2) ? mul_a[63:32] : mul_a[31:0];
  assign mul_y = (mix_step == 2'd1) ? mul_b[63:32] : mul_b[31:0];
  assign prod = {32'd0, mul_x} * {32'd0, mul_y};
  assign len_x = {len_rem, hsh[63:56]};
  assign len_prod = {27'd0, len_x} * {13'd0, LenRecip};
  assign len_q = len_prod[LenRecipShift +: 13];
  assign len_r = len_x - len_q * LenSpanW;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gen_state <= SeedReset;
    end else begin
      if (seed_load) gen_state <= seed_value;
      else if (state == S_IDLE && req_valid && req_bit) gen_state <= x3;
      case (state)
        S_IDLE: begin
          if (req_valid && req_bit) begin
            v <= x3;
            rem <= '0;
            modulus <= (key_universe == '0) ? KuW'(1) : key_universe;
            bit_cnt <= 6'd0;
            state <= S_MOD;
          end
        end
        S_MOD: begin
          // Restoring division, one quotient bit per cycle.
          rem <= rem_next;
          bit_cnt <= bit_cnt + 6'd1;
          if (bit_cnt == 6'd63) begin
            job.key <= rem_next;
            v <= {27'd0, rem_next} + Golden;
            mix_round <= 1'b0;
            mix_step <= 2'd0;
            state <= S_MIX;
          end else begin
            v <= {v[62:0], 1'b0};
          end
        end
        S_MIX: begin
          // Low half of a 64 by 64 product from three 32 by 32 products.
          if (mix_step == 2'd0) begin
            acc <= prod;
            mix_step <= 2'd1;
          end else if (mix_step == 2'd1) begin
            acc <= acc + {prod[31:0], 32'd0};
            mix_step <= 2'd2;
          end else begin
            v <= acc + {prod[31:0], 32'd0};
            mix_step <= 2'd0;
            if (!mix_round) begin
              mix_round <= 1'b1;
            end else begin
              len_cnt <= 4'd0;
              state <= S_LEN;
            end
          end
        end
        S_LEN: begin
          // Remainder by the length span, one byte per cycle.
          if (len_cnt == 4'd0) begin
            hsh <= r3;
            len_rem <= 5'd0;
          end else begin
            hsh <= {hsh[55:0], 8'd0};
            len_rem <= len_r[4:0];
          end
          len_cnt <= len_cnt + 4'd1;
          if (len_cnt == 4'd8) begin
            job.len <= LenW'(MinTokenLen) + LenW'(len_r);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (job_take) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/random_token_generator_unit.sv =====
// Random token generator.
// Input channel: request/request_valid/request_stall; a word with request
// high starts one token, a word with request low is consumed silently.
// Output channel: char_code/last with out_valid/out_stall; one token gives
// its characters then a newline with last high.
// Configuration through the APB port: key_universe at 0, seed at 8.
// Writing seed reloads the generator state at once.
// The front performs a bit-serial modulo reduction of the 64-bit random
// word, then the hashing and the length; the back then divides the key by
// the radix a byte at a time for each digit and buffers the digits.
// The front can work on the next token while the back emits the last one;
// a token is handed over only when the back is idle.
// Reset restores the register defaults and empties the pipeline.
// When the receiver stalls, the output word holds until taken.
module random_token_generator_unit import rtg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic request_valid,
  input  logic request,
  output logic request_stall,
  output logic out_valid,
  output logic [6:0] char_code,
  output logic last,
  input  logic out_stall,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  logic [KuW-1:0] key_universe;
  logic [63:0] seed;
  logic wr, job_valid, job_take, busy;
  rtg_job_t job;
  logic [KeyPadW-1:0] dsh;
  logic [6:0] drem;
  logic [2:0] dstep;
  logic [14:0] dig_x;
  logic [32:0] dig_prod;
  logic [7:0] dig_q;
  logic [14:0] dig_r;
  logic [BufIdxW-1:0] widx;
  logic [6:0] digs [BufDepth];
  logic [LenW-1:0] cnt, len;
  logic phase_out;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx = {1'b0, paddr[3]};
  assign wr = psel && penable && pwrite;
  assign prdata = (ridx == RegKu) ? 64'(key_universe) :
                  (ridx == RegSeed) ? seed : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_universe <= KuReset;
      seed <= SeedReset;
    end else if (wr) begin
      if (ridx == RegKu) key_universe <= pwdata[KuW-1:0];
      if (ridx == RegSeed) seed <= pwdata;
    end
  end

  rtg_front u_front (
    .clk(clk), .rst(rst), .req_valid(request_valid), .req_bit(request),
    .req_stall(request_stall), .key_universe(key_universe),
    .seed_load(wr && ridx == RegSeed), .seed_value(pwdata),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  assign job_take = job_valid && !busy;

  assign dig_x = {drem, dsh[KeyPadW-1 -: 8]};
  assign dig_prod = {18'd0, dig_x} * {15'd0, DigRecip};
  assign dig_q = dig_prod[DigRecipShift +: 8];
  assign dig_r = dig_x - {7'd0, dig_q} * 15'(Radix);
  assign widx = BufIdxW'(cnt - LenW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      phase_out <= 1'b0;
      out_valid <= 1'b0;
    end else if (!busy) begin
      if (job_valid) begin
        busy <= 1'b1;
        phase_out <= 1'b0;
        dsh <= KeyPadW'(job.key);
        drem <= 7'd0;
        dstep <= 3'd0;
        len <= job.len;
        cnt <= job.len;
      end
    end else if (!phase_out) begin
      // Division by the radix a byte at a time; quotient bytes replace the
      // dividend bytes, and digits come out least significant first.
      dsh <= {dsh[KeyPadW-9:0], dig_q};
      if (dstep == 3'(KeyChunks - 1)) begin
        digs[widx] <= glyph(dig_r[6:0]);
        drem <= 7'd0;
        dstep <= 3'd0;
        cnt <= cnt - LenW'(1);
        if (cnt == LenW'(1)) phase_out <= 1'b1;
      end else begin
        drem <= dig_r[6:0];
        dstep <= dstep + 3'd1;
      end
    end else if (!out_valid || !out_stall) begin
      if (out_valid && last) begin
        out_valid <= 1'b0;
        busy <= 1'b0;
      end else begin
        out_valid <= 1'b1;
        if (cnt == len) begin
          char_code <= NlCode;
          last <= 1'b1;
        end else begin
          char_code <= digs[cnt[BufIdxW-1:0]];
          last <= 1'b0;
          cnt <= cnt + LenW'(1);
        end
      end
    end
  end
endmodule
